// File: rtl/core/akt_pkg.sv
// Shared constants for the access key table with sequence guard.
// Used by access_key_table_with_sequence_guard; no dependencies.
package akt_pkg;

	// table geometry
	localparam int NUM_SLOTS = 256;
	localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

	// field widths
	localparam int KEY_W  = 32;
	localparam int SEQ_W  = 16;
	localparam int CODE_W = 2;

	// empty slot and unset sequence markers
	localparam logic [KEY_W-1:0] EMPTY_KEY = {KEY_W{1'b1}};
	localparam logic [SEQ_W-1:0] SEQ_UNSET = {SEQ_W{1'b1}};

	// operations
	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_DEL = 1'b1;

	// result codes
	localparam logic [CODE_W-1:0] RC_DONE  = 2'd0;
	localparam logic [CODE_W-1:0] RC_STALE = 2'd1;
	localparam logic [CODE_W-1:0] RC_MISS  = 2'd2;

endpackage

// File: rtl/core/akt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module akt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/access_key_table_with_sequence_guard.sv
// Access key table with sequence guard. After reset the block writes all NUM_SLOTS
// (256) slots empty and holds in_stall high meanwhile. Each item then
// either adds its key hash to the lowest empty slot or empties the lowest slot that
// holds it, unless its sequence is below the stored one. A refused item goes straight
// to the reply state. Any other item scans the slot RAM, one read a cycle through the
// single comparator, until a slot decides the item or the last slot misses, and then
// enters the reply state. There the reply is registered into the output register once
// that is free, and the block returns to idle to take the next item. One item is worked
// on at a time; a finished reply waits in the output register while the next item is
// accepted, and a reply that is still held there holds back the following one.
// Depends on akt_pkg and akt_ram.
module access_key_table_with_sequence_guard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [akt_pkg::SEQ_W-1:0]      request_seq,
	input  logic [akt_pkg::KEY_W-1:0]      key_hash,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [akt_pkg::CODE_W-1:0]     result_code,
	output logic [akt_pkg::SEQ_W-1:0]      reply_seq
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_REPLY = 2'd3;

	logic [1:0]                      state_q;
	logic [akt_pkg::IDX_W-1:0]       issue_q;
	logic                            issue_on_q;
	logic                            cmp_vld_s1;
	logic [akt_pkg::IDX_W-1:0]       cmp_idx_s1;
	logic [akt_pkg::SEQ_W-1:0]       last_seq_q;
	logic                            out_valid_q;

	logic                            func_q;
	logic [akt_pkg::SEQ_W-1:0]       seq_q;
	logic [akt_pkg::KEY_W-1:0]       hash_q;
	logic [akt_pkg::KEY_W-1:0]       target_q;
	logic [akt_pkg::CODE_W-1:0]      code_q;
	logic [akt_pkg::CODE_W-1:0]      out_code_q;
	logic [akt_pkg::SEQ_W-1:0]       out_seq_q;

	logic                            in_acc;
	logic                            stale;
	logic                            hit;
	logic                            miss;
	logic                            out_free;
	logic                            ram_we;
	logic [akt_pkg::IDX_W-1:0]       ram_waddr;
	logic [akt_pkg::KEY_W-1:0]       ram_wdata;
	logic [akt_pkg::KEY_W-1:0]       ram_rdata;

	// handshake
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// stale when a sequence is stored and exceeds the request's
	assign stale = (last_seq_q != akt_pkg::SEQ_UNSET) && (last_seq_q > request_seq);

	// single comparator on the registered RAM read
	assign hit  = (state_q == ST_SCAN) && cmp_vld_s1 && (ram_rdata == target_q);
	assign miss = (state_q == ST_SCAN) && cmp_vld_s1 && !hit
		&& (cmp_idx_s1 == akt_pkg::LAST_IDX);

	// write port: clearing sweep, or the update of the slot found
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = issue_q;
		ram_wdata = akt_pkg::EMPTY_KEY;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (hit) begin
			ram_we    = 1'b1;
			ram_waddr = cmp_idx_s1;
			ram_wdata = (func_q == akt_pkg::FUNC_ADD) ? hash_q : akt_pkg::EMPTY_KEY;
		end
	end

	akt_ram #(
		.WIDTH(akt_pkg::KEY_W),
		.DEPTH(akt_pkg::NUM_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(issue_q),
		.rdata(ram_rdata)
	);

	// sequencer: clear sweep, scan, reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			issue_q     <= '0;
			issue_on_q  <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			last_seq_q  <= akt_pkg::SEQ_UNSET;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (issue_q == akt_pkg::LAST_IDX) begin
						issue_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						issue_q <= issue_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						issue_q    <= '0;
						cmp_vld_s1 <= 1'b0;
						if (stale) begin
							issue_on_q <= 1'b0;
							state_q    <= ST_REPLY;
						end else begin
							issue_on_q <= 1'b1;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_idx_s1 <= issue_q;
					if (hit) begin
						last_seq_q <= seq_q;
					end
					if (hit || miss) begin
						issue_on_q <= 1'b0;
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_REPLY;
					end else begin
						// advance the read address, one slot a cycle
						cmp_vld_s1 <= issue_on_q;
						if (issue_on_q) begin
							if (issue_q == akt_pkg::LAST_IDX) begin
								issue_on_q <= 1'b0;
							end else begin
								issue_q <= issue_q + 1'b1;
							end
						end
					end
				end
				ST_REPLY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// raise the reply out of the reply state, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_REPLY) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the item and its result code
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q   <= func;
			seq_q    <= request_seq;
			hash_q   <= key_hash;
			target_q <= (func == akt_pkg::FUNC_ADD) ? akt_pkg::EMPTY_KEY : key_hash;
			code_q   <= akt_pkg::RC_STALE;
		end else if (hit) begin
			code_q <= akt_pkg::RC_DONE;
		end else if (miss) begin
			code_q <= akt_pkg::RC_MISS;
		end
		if ((state_q == ST_REPLY) && out_free) begin
			out_code_q <= code_q;
			out_seq_q  <= seq_q;
		end
	end

	assign result_code = out_code_q;
	assign reply_seq   = out_seq_q;

`ifndef SYNTHESIS
	// a slot update during a scan ends the scan
	a_write_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q == ST_SCAN)) |=> (state_q == ST_REPLY))
		else $error("scan continued after slot update");

	// the stored sequence moves only on a successful item
	a_seq_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLY) && (last_seq_q != $past(last_seq_q))
		|-> (code_q == akt_pkg::RC_DONE))
		else $error("sequence updated without success");

	// a reply appears only out of the reply state
	a_reply_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_REPLY))
		else $error("reply raised outside reply state");

	// only defined result codes leave the block
	a_code_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_code_q == akt_pkg::RC_DONE || out_code_q == akt_pkg::RC_STALE
			|| out_code_q == akt_pkg::RC_MISS))
		else $error("undefined result code");
`endif

endmodule
